FILE: hdl/lobm_pkg.sv
// ----------------------------------------------------------------------------
// lobm_pkg
// Shared types, codes and defaults of the limit order book matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package lobm_pkg;

  // default configuration
  localparam int ORDER_SLOTS_DEF = 64;
  localparam int PRICE_BITS_DEF  = 16;
  localparam int REQ_Q_DEPTH     = 2;
  localparam int RES_Q_DEPTH     = 2;

  // request and side codes
  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_CANCEL = 1'b1;
  localparam logic SIDE_BUY   = 1'b0;
  localparam logic SIDE_SELL  = 1'b1;

  // result kinds
  localparam logic KIND_TRADE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [2:0] {
    STAT_RESTED    = 3'd0,
    STAT_FILLED    = 3'd1,
    STAT_CANCELLED = 3'd2,
    STAT_UNKNOWN   = 3'd3,
    STAT_FULL      = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_XSCAN,
    S_XDECIDE,
    S_CSCAN,
    S_BSCAN,
    S_FINAL
  } eng_state_t;

  typedef struct packed {
    logic        cmd;
    logic [31:0] order_id;
    logic        side;
    logic [15:0] price;
    logic [31:0] quantity;
  } req_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] taker_id;
    logic [31:0] maker_id;
    logic [15:0] trade_price;
    logic [31:0] trade_qty;
    status_t     status;
    logic [15:0] best_bid;
    logic [15:0] best_ask;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

FILE: hdl/lobm_fifo.sv
// ----------------------------------------------------------------------------
// lobm_fifo
// Small register queue used between the ports and the matching engine.
// ----------------------------------------------------------------------------
`default_nettype none

module lobm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = store[rptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + AW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + AW'(1);
      end
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/lobm_engine.sv
// ----------------------------------------------------------------------------
// lobm_engine
// Back end: scans the slot table one slot per cycle to cross, rest, cancel
// and find the best prices, then pushes results into the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lobm_engine #(
  parameter int ORDER_SLOTS = lobm_pkg::ORDER_SLOTS_DEF,
  parameter int PRICE_BITS  = lobm_pkg::PRICE_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  input  wire lobm_pkg::req_t req_in,
  output logic               req_pop,
  input  wire logic          res_full,
  output logic               res_push,
  output lobm_pkg::res_t     res_out
);

  localparam int SW = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
  localparam int P  = PRICE_BITS;
  localparam logic [P-1:0] PRICE_MASK = {P{1'b1}};

  // slot memories
  logic [31:0] id_mem    [ORDER_SLOTS];
  logic        side_mem  [ORDER_SLOTS];
  logic [P-1:0] price_mem[ORDER_SLOTS];
  logic [31:0] arr_mem   [ORDER_SLOTS];
  logic [31:0] rem_mem   [ORDER_SLOTS];

  lobm_pkg::eng_state_t state;
  lobm_pkg::eng_state_t state_next;

  lobm_pkg::req_t   req;
  lobm_pkg::res_t   pend;
  lobm_pkg::status_t status_r;
  logic             pend_v;
  logic [31:0]      rem;
  logic [SW:0]      trade_cnt;
  logic [ORDER_SLOTS-1:0] live;
  logic [31:0]      ctr;

  // scan pipeline
  logic [SW:0]   scan_idx;
  logic          proc_v;
  logic [SW-1:0] proc_idx;
  logic [31:0]   rd_id;
  logic          rd_side;
  logic [P-1:0]  rd_price;
  logic [31:0]   rd_arr;
  logic [31:0]   rd_rem;

  // trackers
  logic          bfound;
  logic [SW-1:0] bidx;
  logic [P-1:0]  bprice;
  logic [31:0]   bage;
  logic [31:0]   bid_id;
  logic [31:0]   brem;
  logic          ffound;
  logic [SW-1:0] fidx;
  logic          hfound;
  logic [SW-1:0] hidx;
  logic [31:0]   hage;
  logic          have_bid;
  logic [P-1:0]  bb;
  logic          have_ask;
  logic [P-1:0]  ba;

  // combinational helpers
  logic          scan_state;
  logic          issue;
  logic          scan_done;
  logic          start_scan;
  logic          cross_ok;
  logic          fill_go;
  logic          rest_go;
  logic [31:0]   fill_t;
  logic [31:0]   rem_after;
  logic [31:0]   brem_after;
  logic [31:0]   age;
  logic          want;
  logic [P-1:0]  lim;
  logic [31:0]   price32;
  logic [31:0]   bb32;
  logic [31:0]   ba32;
  logic [31:0]   bp32;
  logic          x_hit;
  logic          x_better;
  logic          lv;

  assign price32    = {16'b0, req.price};
  assign lim        = price32[P-1:0];
  assign want       = ~req.side;
  assign scan_state = (state inside {lobm_pkg::S_XSCAN, lobm_pkg::S_CSCAN, lobm_pkg::S_BSCAN});
  assign issue      = scan_state && (scan_idx < (SW+1)'(ORDER_SLOTS));
  assign scan_done  = scan_state && (scan_idx == (SW+1)'(ORDER_SLOTS)) && !proc_v;
  assign cross_ok   = bfound && (trade_cnt < (SW+1)'(ORDER_SLOTS));
  assign fill_t     = (rem < brem) ? rem : brem;
  assign rem_after  = rem - fill_t;
  assign brem_after = brem - fill_t;
  assign age        = ctr - rd_arr;
  assign lv         = live[proc_idx];
  assign bb32       = 32'(bb);
  assign ba32       = 32'(ba);
  assign bp32       = 32'(bprice);

  // crossing test on the slot under processing
  assign x_hit = lv && (rd_side == want) &&
                 ((want == lobm_pkg::SIDE_SELL) ? (rd_price <= lim) : (rd_price >= lim));
  assign x_better = !bfound ||
                    ((rd_price == bprice) ? (age > bage) :
                     ((want == lobm_pkg::SIDE_SELL) ? (rd_price < bprice) : (rd_price > bprice)));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      lobm_pkg::S_IDLE: begin
        if (req_valid) begin
          if (req_in.cmd == lobm_pkg::CMD_CANCEL) state_next = lobm_pkg::S_CSCAN;
          else if (req_in.quantity == '0) state_next = lobm_pkg::S_BSCAN;
          else state_next = lobm_pkg::S_XSCAN;
        end
      end
      lobm_pkg::S_XSCAN: begin
        if (scan_done) state_next = lobm_pkg::S_XDECIDE;
      end
      lobm_pkg::S_XDECIDE: begin
        if (cross_ok) begin
          if (!(pend_v && res_full)) begin
            state_next = (rem_after == '0) ? lobm_pkg::S_BSCAN : lobm_pkg::S_XSCAN;
          end
        end else begin
          state_next = lobm_pkg::S_BSCAN;
        end
      end
      lobm_pkg::S_CSCAN: begin
        if (scan_done) state_next = lobm_pkg::S_BSCAN;
      end
      lobm_pkg::S_BSCAN: begin
        if (scan_done) state_next = lobm_pkg::S_FINAL;
      end
      lobm_pkg::S_FINAL: begin
        if (!res_full) state_next = lobm_pkg::S_IDLE;
      end
      default: state_next = lobm_pkg::S_IDLE;
    endcase
  end

  // control outputs and result record
  always_comb begin
    req_pop    = (state == lobm_pkg::S_IDLE) && req_valid;
    start_scan = (state_next != state) &&
                 (state_next inside {lobm_pkg::S_XSCAN, lobm_pkg::S_CSCAN, lobm_pkg::S_BSCAN});
    fill_go    = (state == lobm_pkg::S_XDECIDE) && cross_ok && !(pend_v && res_full);
    rest_go    = (state == lobm_pkg::S_XDECIDE) && !cross_ok && ffound;
    res_push   = (fill_go && pend_v) || ((state == lobm_pkg::S_FINAL) && !res_full);
    res_out    = pend;
    if (state == lobm_pkg::S_FINAL) begin
      if (!pend_v) begin
        res_out      = '0;
        res_out.kind = lobm_pkg::KIND_STATUS;
      end
      res_out.status   = status_r;
      res_out.best_bid = bb32[15:0];
      res_out.best_ask = ba32[15:0];
      res_out.last     = 1'b1;
    end
  end

  // slot memories: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (rest_go) begin
      id_mem[fidx]    <= req.order_id;
      side_mem[fidx]  <= req.side;
      price_mem[fidx] <= lim;
      arr_mem[fidx]   <= ctr;
      rem_mem[fidx]   <= rem;
    end else if (fill_go) begin
      rem_mem[bidx] <= brem_after;
    end
    if (issue) begin
      rd_id    <= id_mem[scan_idx[SW-1:0]];
      rd_side  <= side_mem[scan_idx[SW-1:0]];
      rd_price <= price_mem[scan_idx[SW-1:0]];
      rd_arr   <= arr_mem[scan_idx[SW-1:0]];
      rd_rem   <= rem_mem[scan_idx[SW-1:0]];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lobm_pkg::S_IDLE;
      live      <= '0;
      ctr       <= '0;
      pend_v    <= 1'b0;
      proc_v    <= 1'b0;
      scan_idx  <= '0;
      trade_cnt <= '0;
      bfound    <= 1'b0;
      ffound    <= 1'b0;
      hfound    <= 1'b0;
      have_bid  <= 1'b0;
      have_ask  <= 1'b0;
    end else begin
      state <= state_next;

      // request intake
      if (req_pop) begin
        req       <= req_in;
        rem       <= req_in.quantity;
        trade_cnt <= '0;
        pend_v    <= 1'b0;
        status_r  <= (req_in.quantity == '0) ? lobm_pkg::STAT_FILLED : lobm_pkg::STAT_RESTED;
      end

      // scan address and pipeline
      if (start_scan) begin
        scan_idx <= '0;
        proc_v   <= 1'b0;
        bfound   <= 1'b0;
        ffound   <= 1'b0;
        hfound   <= 1'b0;
        have_bid <= 1'b0;
        have_ask <= 1'b0;
        bb       <= PRICE_MASK;
        ba       <= '0;
      end else begin
        if (issue) scan_idx <= scan_idx + (SW+1)'(1);
        proc_v   <= issue;
        proc_idx <= scan_idx[SW-1:0];
      end

      // per-slot processing
      if (proc_v && !start_scan) begin
        case (state)
          lobm_pkg::S_XSCAN: begin
            if (x_hit && x_better) begin
              bfound <= 1'b1;
              bidx   <= proc_idx;
              bprice <= rd_price;
              bage   <= age;
              bid_id <= rd_id;
              brem   <= rd_rem;
            end
            if (!lv && !ffound) begin
              ffound <= 1'b1;
              fidx   <= proc_idx;
            end
          end
          lobm_pkg::S_CSCAN: begin
            if (lv && (rd_id == req.order_id) && (!hfound || (age < hage))) begin
              hfound <= 1'b1;
              hidx   <= proc_idx;
              hage   <= age;
            end
          end
          lobm_pkg::S_BSCAN: begin
            if (lv) begin
              if (rd_side == lobm_pkg::SIDE_BUY) begin
                if (!have_bid || (rd_price > bb)) bb <= rd_price;
                have_bid <= 1'b1;
              end else begin
                if (!have_ask || (rd_price < ba)) ba <= rd_price;
                have_ask <= 1'b1;
              end
            end
          end
          default: ;
        endcase
      end

      // one fill against the best crossing slot
      if (fill_go) begin
        pend <= '{kind:        lobm_pkg::KIND_TRADE,
                  taker_id:    req.order_id,
                  maker_id:    bid_id,
                  trade_price: bp32[15:0],
                  trade_qty:   fill_t,
                  status:      lobm_pkg::STAT_RESTED,
                  best_bid:    16'd0,
                  best_ask:    16'd0,
                  last:        1'b0};
        pend_v           <= 1'b1;
        trade_cnt        <= trade_cnt + (SW+1)'(1);
        rem              <= rem_after;
        if (brem_after == '0) live[bidx] <= 1'b0;
        if (rem_after == '0) status_r <= lobm_pkg::STAT_FILLED;
      end

      // rest the remainder or reject it
      if ((state == lobm_pkg::S_XDECIDE) && !cross_ok) begin
        if (ffound) begin
          live[fidx] <= 1'b1;
          ctr        <= ctr + 32'd1;
          status_r   <= lobm_pkg::STAT_RESTED;
        end else begin
          status_r <= lobm_pkg::STAT_FULL;
        end
      end

      // cancel outcome
      if ((state == lobm_pkg::S_CSCAN) && scan_done) begin
        if (hfound) begin
          live[hidx] <= 1'b0;
          status_r   <= lobm_pkg::STAT_CANCELLED;
        end else begin
          status_r <= lobm_pkg::STAT_UNKNOWN;
        end
      end
    end
  end

  // checks
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full) else $error("result transfer into a full queue");

  a_trade_cap: assert property (@(posedge clk) disable iff (rst)
    trade_cnt <= (SW+1)'(ORDER_SLOTS)) else $error("trade count beyond slot count");

  a_best_live: assert property (@(posedge clk) disable iff (rst)
    ((state == lobm_pkg::S_XDECIDE) && bfound) |-> (brem != '0))
    else $error("crossing slot with nothing remaining");

  a_fill_next: assert property (@(posedge clk) disable iff (rst)
    fill_go |=> ((state == lobm_pkg::S_XSCAN) || (state == lobm_pkg::S_BSCAN)))
    else $error("fill not followed by a rescan");

endmodule

`default_nettype wire

FILE: hdl/limit_order_book_matcher.sv
// ----------------------------------------------------------------------------
// limit_order_book_matcher
// Price-time priority order book: add and cancel requests in, trades and
// status results out.
// ----------------------------------------------------------------------------
// Usage: requests enter through a queue-style port (push/full) and results
// leave through a queue-style port (empty/pop). A small request queue feeds
// the matching engine and a small result queue decouples it from the
// consumer, so the producer may push the next request while results wait.
// Each request gives one or more results; the final one has last set and
// carries status and best bid/ask.
// Timing: the engine walks the slot table one slot per cycle through a
// registered memory read. A cancel takes two passes, a zero-quantity add
// one pass. An add with k fills takes k crossing passes when the last fill
// completes it and k+1 otherwise, each followed by a decide step, plus one
// best-price pass. Requests are handled one at a time.
// Reset: rst (synchronous) empties both queues and the book.
// Stalls: when the consumer holds off pop the result queue fills and the
// engine waits; once the request queue is full, full stays high.
// ----------------------------------------------------------------------------
`default_nettype none

module limit_order_book_matcher #(
  parameter int ORDER_SLOTS = lobm_pkg::ORDER_SLOTS_DEF,
  parameter int PRICE_BITS  = lobm_pkg::PRICE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic        cmd,
  input  wire logic [31:0] order_id,
  input  wire logic        side,
  input  wire logic [15:0] price,
  input  wire logic [31:0] quantity,
  output logic             empty,
  input  wire logic        pop,
  output logic             kind,
  output logic      [31:0] taker_id,
  output logic      [31:0] maker_id,
  output logic      [15:0] trade_price,
  output logic      [31:0] trade_qty,
  output logic      [2:0]  status,
  output logic      [15:0] best_bid,
  output logic      [15:0] best_ask,
  output logic             last
);

  lobm_pkg::req_t req_w;
  lobm_pkg::req_t req_q;
  lobm_pkg::res_t res_w;
  lobm_pkg::res_t res_q;
  logic           req_empty;
  logic           req_pop;
  logic           res_full;
  logic           res_push;

  // request packing
  always_comb begin
    req_w.cmd      = cmd;
    req_w.order_id = order_id;
    req_w.side     = side;
    req_w.price    = price;
    req_w.quantity = quantity;
  end

  // request queue
  lobm_fifo #(
    .WIDTH ($bits(lobm_pkg::req_t)),
    .DEPTH (lobm_pkg::REQ_Q_DEPTH)
  ) u_req_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (req_w),
    .full  (full),
    .pop   (req_pop),
    .rdata (req_q),
    .empty (req_empty)
  );

  // matching engine
  lobm_engine #(
    .ORDER_SLOTS (ORDER_SLOTS),
    .PRICE_BITS  (PRICE_BITS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .req_valid (!req_empty),
    .req_in    (req_q),
    .req_pop   (req_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_out   (res_w)
  );

  // result queue
  lobm_fifo #(
    .WIDTH ($bits(lobm_pkg::res_t)),
    .DEPTH (lobm_pkg::RES_Q_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_w),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_q),
    .empty (empty)
  );

  // result unpacking
  assign kind        = res_q.kind;
  assign taker_id    = res_q.taker_id;
  assign maker_id    = res_q.maker_id;
  assign trade_price = res_q.trade_price;
  assign trade_qty   = res_q.trade_qty;
  assign status      = res_q.status;
  assign best_bid    = res_q.best_bid;
  assign best_ask    = res_q.best_ask;
  assign last        = res_q.last;

endmodule

`default_nettype wire
